[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled during reset.
`define CHK_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed: label");

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed: label");

`else

`define CHK_IMPLIES(label, clk, rst, ante, cons)
`define CHK_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/lfow_pkg.sv]
`timescale 1ns / 1ps

package lfow_pkg;

  localparam int DEPTH         = 256;
  localparam int PAYLOAD_WIDTH = 32;
  localparam int LEVEL_WIDTH   = 3;

  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CMP_W   = (ADDR_W > 8) ? ADDR_W : 8;
  localparam int ENTRY_W = LEVEL_WIDTH + PAYLOAD_WIDTH;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int OCC_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_STOP = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED  = 3'd0,
    ST_DROPPED = 3'd1,
    ST_HELD    = 3'd2,
    ST_STOPPED = 3'd3,
    ST_POPPED  = 3'd4,
    ST_EMPTY   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    MODE_HOLD         = 2'd0,
    MODE_DROP_ALL     = 2'd1,
    MODE_DROP_NONCRIT = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OVERFLOW_MODE  = 2'd0,
    REG_HIGH_THRESHOLD = 2'd1,
    REG_LOW_THRESHOLD  = 2'd2,
    REG_CRITICAL_CODE  = 2'd3
  } reg_idx_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_t;

endpackage

[rtl/log_fifo_overflow_watermark.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Log FIFO holding up to DEPTH-1 level/payload entries, with a full policy
// (hold, drop all, drop non-critical) and a high-watermark flag that clears at
// the low threshold. Pulse start with cmd and entry fields while busy is low;
// busy is then high for one cycle, and in the next cycle the result appears
// on the result ports with done high for exactly one cycle. The receiver
// cannot stall, so take the result when done is seen. An item is handled in
// steps: the registered read of the entry memory at start, then the update
// of pointers and result registers; a new start is taken in the cycle done
// is high. A held push reports status 2 and must be retried by the sender.
// Configuration writes (cfg_ready is always high) belong in idle periods.
module log_fifo_overflow_watermark (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [lfow_pkg::CMD_W-1:0]          cmd,
  input  logic [lfow_pkg::LEVEL_WIDTH-1:0]    entry_level,
  input  logic [lfow_pkg::PAYLOAD_WIDTH-1:0]  entry_payload,
  output logic                                done,
  output logic [lfow_pkg::STATUS_W-1:0]       status,
  output logic [lfow_pkg::LEVEL_WIDTH-1:0]    out_level,
  output logic [lfow_pkg::PAYLOAD_WIDTH-1:0]  out_payload,
  output logic [lfow_pkg::OCC_W-1:0]          occupancy,
  output logic                                high_flag,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lfow_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lfow_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lfow_pkg::*;

  ctrl_t ctrl;

  assign cfg_ready = 1'b1;

  lfow_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctrl  (ctrl)
  );

  lfow_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .cmd           (cmd),
    .entry_level   (entry_level),
    .entry_payload (entry_payload),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .status        (status),
    .out_level     (out_level),
    .out_payload   (out_payload),
    .occupancy     (occupancy),
    .high_flag     (high_flag)
  );

  `CHK_NEXT(a_accept_busy, clk, rst, start && !busy, busy && !done)
  `CHK_NEXT(a_busy_done, clk, rst, busy, done && !busy)
  `CHK_IMPLIES(a_empty_occ, clk, rst, done && status == ST_EMPTY, occupancy == '0)
  `CHK_IMPLIES(a_idle_payload, clk, rst, done && status != ST_POPPED, out_payload == '0 && out_level == '0)

endmodule

[rtl/lfow_ctrl.sv]
`timescale 1ns / 1ps

module lfow_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  output logic           done,
  output lfow_pkg::ctrl_t ctrl
);
  import lfow_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ctrl.exec;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl = '0;
    busy = 1'b0;
    case (state)
      S_IDLE: begin
        ctrl.load = start;
      end
      S_EXEC: begin
        ctrl.exec = 1'b1;
        busy      = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

[rtl/lfow_dpath.sv]
`timescale 1ns / 1ps

module lfow_dpath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  lfow_pkg::ctrl_t                      ctrl,
  input  logic [lfow_pkg::CMD_W-1:0]           cmd,
  input  logic [lfow_pkg::LEVEL_WIDTH-1:0]     entry_level,
  input  logic [lfow_pkg::PAYLOAD_WIDTH-1:0]   entry_payload,
  input  logic                                 cfg_we,
  input  logic [lfow_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lfow_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic [lfow_pkg::STATUS_W-1:0]        status,
  output logic [lfow_pkg::LEVEL_WIDTH-1:0]     out_level,
  output logic [lfow_pkg::PAYLOAD_WIDTH-1:0]   out_payload,
  output logic [lfow_pkg::OCC_W-1:0]           occupancy,
  output logic                                 high_flag
);
  import lfow_pkg::*;

  // config
  logic [1:0]             overflow_mode;
  logic [7:0]             high_threshold;
  logic [7:0]             low_threshold;
  logic [LEVEL_WIDTH-1:0] critical_code;

  // queue state
  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0]  write_ptr;
  logic [ADDR_W-1:0]  read_ptr;
  logic [ADDR_W-1:0]  count;
  logic               tripped;
  logic               running;

  // latched item
  logic [CMD_W-1:0]         cmd_q;
  logic [LEVEL_WIDTH-1:0]   level_q;
  logic [PAYLOAD_WIDTH-1:0] payload_q;
  logic [ENTRY_W-1:0]       rd_data;

  logic [ADDR_W-1:0]        write_ptr_next;
  logic [ADDR_W-1:0]        read_ptr_next;
  logic [ADDR_W-1:0]        count_next;
  logic                     tripped_next;
  logic                     running_next;
  logic                     wr_en;
  status_t                  status_next;
  logic [LEVEL_WIDTH-1:0]   level_next;
  logic [PAYLOAD_WIDTH-1:0] payload_next;
  logic [CMP_W-1:0]         count_inc;
  logic [CMP_W-1:0]         count_dec;
  logic [CMP_W-1:0]         count_ext;
  logic [CMP_W-1:0]         occ_ext;
  logic                     full;
  logic                     empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_mode  <= MODE_HOLD;
      high_threshold <= 8'd192;
      low_threshold  <= 8'd64;
      critical_code  <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OVERFLOW_MODE:  overflow_mode  <= cfg_data[1:0];
        REG_HIGH_THRESHOLD: high_threshold <= cfg_data;
        REG_LOW_THRESHOLD:  low_threshold  <= cfg_data;
        REG_CRITICAL_CODE:  critical_code  <= cfg_data[LEVEL_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q     <= cmd;
      level_q   <= entry_level;
      payload_q <= entry_payload;
      rd_data   <= mem[read_ptr];
    end
    if (wr_en) begin
      mem[write_ptr] <= {level_q, payload_q};
    end
  end

  assign full      = (count == ADDR_W'(DEPTH - 1));
  assign empty     = (count == '0);
  assign count_ext = CMP_W'(count);
  assign count_inc = count_ext + CMP_W'(1);
  assign count_dec = count_ext - CMP_W'(1);

  always_comb begin
    write_ptr_next = write_ptr;
    read_ptr_next  = read_ptr;
    count_next     = count;
    tripped_next   = tripped;
    running_next   = running;
    wr_en          = 1'b0;
    status_next    = ST_STOPPED;
    level_next     = '0;
    payload_next   = '0;
    if (!running) begin
      status_next = ST_STOPPED;
    end else begin
      case (cmd_q)
        CMD_PUSH: begin
          if (full) begin
            if (overflow_mode == MODE_DROP_ALL) begin
              status_next = ST_DROPPED;
            end else if (overflow_mode == MODE_DROP_NONCRIT && level_q != critical_code) begin
              status_next = ST_DROPPED;
            end else begin
              status_next = ST_HELD;
            end
          end else begin
            wr_en          = 1'b1;
            write_ptr_next = (write_ptr == ADDR_W'(DEPTH - 1)) ? '0 : write_ptr + 1'b1;
            count_next     = count + 1'b1;
            if (count_inc >= CMP_W'(high_threshold)) tripped_next = 1'b1;
            status_next = ST_PUSHED;
          end
        end
        CMD_POP: begin
          if (empty) begin
            status_next = ST_EMPTY;
          end else begin
            level_next    = rd_data[ENTRY_W-1:PAYLOAD_WIDTH];
            payload_next  = rd_data[PAYLOAD_WIDTH-1:0];
            read_ptr_next = (read_ptr == ADDR_W'(DEPTH - 1)) ? '0 : read_ptr + 1'b1;
            count_next    = count - 1'b1;
            if (count_dec <= CMP_W'(low_threshold)) tripped_next = 1'b0;
            status_next = ST_POPPED;
          end
        end
        default: begin
          running_next = 1'b0;
          status_next  = ST_STOPPED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr <= '0;
      read_ptr  <= '0;
      count     <= '0;
      tripped   <= 1'b0;
      running   <= 1'b1;
    end else if (ctrl.exec) begin
      write_ptr <= write_ptr_next;
      read_ptr  <= read_ptr_next;
      count     <= count_next;
      tripped   <= tripped_next;
      running   <= running_next;
    end
  end

  assign occ_ext = CMP_W'(count_next);

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      status      <= status_next;
      out_level   <= level_next;
      out_payload <= payload_next;
      occupancy   <= (occ_ext > CMP_W'(255)) ? 8'hFF : occ_ext[OCC_W-1:0];
      high_flag   <= tripped_next;
    end
  end

endmodule
